[design/arpc_pkg.sv]
// Shared types, constants and helpers for the address translation cache.
package arpc_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int IP_W          = 32;
  localparam int MAC_W         = 48;
  localparam int TIME_W        = 32;
  localparam int IN_DATA_W     = 112;
  localparam int OUT_DATA_W    = 80;
  localparam int OUT_USER_W    = 2;

  localparam logic OP_INSTALL = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    idx_t   raddr;
  } ram_req_t;

  typedef struct packed {
    logic              req;
    logic [IP_W-1:0]   req_addr;
    logic              found;
    logic [MAC_W-1:0]  dest_mac;
  } res_t;

  function automatic idx_t next_idx(input idx_t s);
    idx_t r;
    if (s == idx_t'(TABLE_ENTRIES - 1)) begin
      r = '0;
    end else begin
      r = s + idx_t'(1);
    end
    return r;
  endfunction

endpackage

[design/arpc_ram.sv]
// Generic simple dual-port RAM with registered read.
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/arpc_ctrl.sv]
// Probe sequencer: linear probe, LRU victim choice, read-modify-write of the table.
module arpc_ctrl import arpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_tuser,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  entry_t               rd_data,
  output ram_req_t             ram_req,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res
);

  typedef enum logic [1:0] {ST_IDLE, ST_PROBE, ST_RESULT} state_t;

  state_t              state_r, state_nxt;
  logic                op_r, op_nxt;
  logic [IP_W-1:0]     ip_r, ip_nxt;
  logic [MAC_W-1:0]    mac_r, mac_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  idx_t                slot_r, slot_nxt;
  idx_t                cnt_r, cnt_nxt;
  idx_t                victim_r, victim_nxt;
  logic [TIME_W-1:0]   vtime_r, vtime_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic                vq_r;
  res_t                res_r, res_nxt;

  logic [IP_W-1:0]     e_ip;
  logic                empty, match, last;
  logic [IP_W-1:0]     in_ip;

  assign in_ip     = in_tdata[IP_W-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESULT);
  assign res       = res_r;

  assign e_ip  = vq_r ? rd_data.ip : '0;
  assign empty = (e_ip == '0);
  assign match = (e_ip == ip_r);
  assign last  = (cnt_r == idx_t'(TABLE_ENTRIES - 1));

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    ip_nxt     = ip_r;
    mac_nxt    = mac_r;
    now_nxt    = now_r;
    slot_nxt   = slot_r;
    cnt_nxt    = cnt_r;
    victim_nxt = victim_r;
    vtime_nxt  = vtime_r;
    res_nxt    = res_r;

    ram_req.we    = 1'b0;
    ram_req.waddr = slot_r;
    ram_req.wdata = '{ip: ip_r, mac: mac_r, stamp: now_r};
    ram_req.raddr = next_idx(slot_r);

    unique case (state_r)
      ST_IDLE: begin
        ram_req.raddr = in_ip[IDX_W-1:0];
        if (in_tvalid) begin
          op_nxt     = in_tuser;
          ip_nxt     = in_ip;
          mac_nxt    = in_tdata[IP_W +: MAC_W];
          now_nxt    = in_tdata[IP_W+MAC_W +: TIME_W];
          slot_nxt   = in_ip[IDX_W-1:0];
          victim_nxt = in_ip[IDX_W-1:0];
          cnt_nxt    = '0;
          res_nxt    = '0;
          if (in_ip == '0) begin
            res_nxt.req = (in_tuser == OP_RESOLVE);
            state_nxt   = ST_RESULT;
          end else begin
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        cnt_nxt  = cnt_r + idx_t'(1);
        slot_nxt = next_idx(slot_r);
        if (op_r == OP_INSTALL) begin
          if (cnt_r == '0 || rd_data.stamp < vtime_r) begin
            victim_nxt = slot_r;
            vtime_nxt  = rd_data.stamp;
          end
          if (empty || match) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = slot_r;
            state_nxt     = ST_RESULT;
          end else if (last) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = victim_nxt;
            state_nxt     = ST_RESULT;
          end
        end else begin
          if (empty || (last && !match)) begin
            res_nxt.req      = 1'b1;
            res_nxt.req_addr = ip_r;
            state_nxt        = ST_RESULT;
          end else if (match) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = slot_r;
            ram_req.wdata = '{ip: rd_data.ip, mac: rd_data.mac, stamp: now_r};
            res_nxt.found    = 1'b1;
            res_nxt.dest_mac = rd_data.mac;
            state_nxt        = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      vq_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vq_r    <= valid_r[ram_req.raddr];
      if (ram_req.we) begin
        valid_r[ram_req.waddr] <= 1'b1;
      end
    end
    op_r     <= op_nxt;
    ip_r     <= ip_nxt;
    mac_r    <= mac_nxt;
    now_r    <= now_nxt;
    slot_r   <= slot_nxt;
    cnt_r    <= cnt_nxt;
    victim_r <= victim_nxt;
    vtime_r  <= vtime_nxt;
    res_r    <= res_nxt;
  end

endmodule

[design/arp_cache_linear_probe_lru.sv]
// Top level of the address translation cache: table RAM, probe sequencer, output register.
//
// Input stream (in_*): one transaction per request. in_tuser selects install (0) or
// resolve (1); in_tdata carries the internet address, Ethernet address and current time.
// Output stream (out_*): exactly one transaction per request. out_tuser flags a hit or a
// resolution request; out_tdata carries the resolved Ethernet address and request address.
// The table lives in one RAM of TABLE_ENTRIES words with a registered read; the
// sequencer probes one slot per cycle from the home slot (address mod table size).
// The idle state accepts a request and issues the first read, then the sequencer examines
// the probed slots in turn (1 to TABLE_ENTRIES, none for the reserved address) and hands
// the result to the output register. A hit or an install into an empty or matching slot is
// written as examined, an eviction with the last slot. One request is in flight at a time.
// Reset empties the table at once through per-slot valid bits; no clearing sweep is needed.
// The output register lets the next request be accepted while a result waits; if the
// receiver stalls, a second finished result waits in the sequencer and input is held off.
module arp_cache_linear_probe_lru import arpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tuser,   // op
  input  logic [IN_DATA_W-1:0]  in_tdata,   // ip_addr, mac_addr, timestamp
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_USER_W-1:0] out_tuser,  // found, request_resolution
  output logic [OUT_DATA_W-1:0] out_tdata   // dest_mac, request_addr
);

  ram_req_t ram_req;
  entry_t   rd_data;
  logic [ENTRY_W-1:0] rd_bits;
  logic     res_valid, res_ready;
  res_t     res;

  logic                  out_valid_r;
  logic [OUT_USER_W-1:0] out_user_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  arpc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (rd_bits)
  );

  assign rd_data = entry_t'(rd_bits);

  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .rd_data   (rd_data),
    .ram_req   (ram_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_user_r <= {res.req, res.found};
      out_data_r <= {res.req_addr, res.dest_mac};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

endmodule

[bench/arp_cache_linear_probe_lru_tb.sv]
// Testbench for the address translation cache: random and directed install/resolve traffic.
`timescale 1ns / 1ps

module arp_cache_linear_probe_lru_tb;
  import arpc_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int LONG_HOLD    = 400;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 190;
  localparam int MAX_PRINTS   = 100;

  typedef struct packed {
    logic              op;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] stamp;
    logic [7:0]        gap;
    logic              drain_first;
    logic              hold_rx;
  } arp_req_t;

  typedef struct packed {
    logic             found;
    logic [MAC_W-1:0] dest_mac;
    logic             request;
    logic [IP_W-1:0]  request_addr;
  } arp_answer_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic                  in_tuser   = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_USER_W-1:0] out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;

  // shadow copy of the cache contents
  logic [IP_W-1:0]   tbl_ip    [TABLE_ENTRIES];
  logic [MAC_W-1:0]  tbl_mac   [TABLE_ENTRIES];
  logic [TIME_W-1:0] tbl_stamp [TABLE_ENTRIES];

  arp_req_t    pending_reqs[$];
  arp_answer_t expected_answers[$];
  arp_req_t    cur;

  int   idle_cnt   = 0;
  int   n_accepted = 0;
  int   n_results  = 0;
  int   err_count  = 0;
  int   cycle_cnt  = 0;
  int   stall_left = 0;
  int   hold_left  = 0;
  logic rx_hold_go = 1'b0;

  // stimulus generation controls
  int          calm_left  = 0;
  logic        mark_drain = 1'b0;
  logic        mark_hold  = 1'b0;
  logic [31:0] clock_now  = '0;

  arp_cache_linear_probe_lru dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int draw_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [MAC_W-1:0] draw_mac();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return {16'($urandom()), 32'($urandom())};
  endfunction

  // probe, update the shadow table and return the answer the cache must give
  function automatic arp_answer_t lookup_and_update(input arp_req_t r);
    arp_answer_t a;
    int          s;
    int          victim;
    int          n;
    logic        done;
    logic        hit;
    a      = '0;
    s      = int'(r.ip % TABLE_ENTRIES);
    victim = s;
    done   = 1'b0;
    hit    = 1'b0;
    if (r.op == OP_INSTALL) begin
      if (r.ip != '0) begin
        for (n = 0; n < TABLE_ENTRIES; n++) begin
          if (!done) begin
            if (tbl_ip[s] == '0 || tbl_ip[s] == r.ip) begin
              victim = s;
              done   = 1'b1;
            end else begin
              if (tbl_stamp[s] < tbl_stamp[victim]) victim = s;
              s = (s == TABLE_ENTRIES - 1) ? 0 : s + 1;
            end
          end
        end
        tbl_ip[victim]    = r.ip;
        tbl_mac[victim]   = r.mac;
        tbl_stamp[victim] = r.stamp;
      end
    end else begin
      if (r.ip != '0) begin
        for (n = 0; n < TABLE_ENTRIES; n++) begin
          if (!done) begin
            if (tbl_ip[s] == '0) begin
              done = 1'b1;
            end else if (tbl_ip[s] == r.ip) begin
              tbl_stamp[s] = r.stamp;
              a.found      = 1'b1;
              a.dest_mac   = tbl_mac[s];
              hit          = 1'b1;
              done         = 1'b1;
            end else begin
              s = (s == TABLE_ENTRIES - 1) ? 0 : s + 1;
            end
          end
        end
      end
      if (!hit) begin
        a.request      = 1'b1;
        a.request_addr = r.ip;
      end
    end
    return a;
  endfunction

  task automatic add_item(input logic op, input logic [IP_W-1:0] ip,
                          input logic [MAC_W-1:0] mac, input logic [TIME_W-1:0] stamp);
    arp_req_t it;
    it.op          = op;
    it.ip          = ip;
    it.mac         = mac;
    it.stamp       = stamp;
    it.gap         = (calm_left > 0) ? 8'd0 : 8'(draw_idle());
    it.drain_first = mark_drain;
    it.hold_rx     = mark_hold;
    if (calm_left > 0) calm_left--;
    mark_drain = 1'b0;
    mark_hold  = 1'b0;
    pending_reqs.push_back(it);
  endtask

  task automatic report_mismatch(input string what, input logic [95:0] got,
                                 input logic [95:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("result %0d: %s is %h, expected %h", n_results, what, got, want);
  endtask

  task automatic check_answer();
    arp_answer_t want;
    if (expected_answers.size() == 0) begin
      report_mismatch("unexpected transaction", 96'({out_tuser, out_tdata}), '0);
    end else begin
      want = expected_answers.pop_front();
      if (out_tuser[0] !== want.found)
        report_mismatch("found", 96'(out_tuser[0]), 96'(want.found));
      if (out_tuser[1] !== want.request)
        report_mismatch("request_resolution", 96'(out_tuser[1]), 96'(want.request));
      if (out_tdata[MAC_W-1:0] !== want.dest_mac)
        report_mismatch("dest_mac", 96'(out_tdata[MAC_W-1:0]), 96'(want.dest_mac));
      if (out_tdata[OUT_DATA_W-1:MAC_W] !== want.request_addr)
        report_mismatch("request_addr", 96'(out_tdata[OUT_DATA_W-1:MAC_W]),
                        96'(want.request_addr));
    end
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    int   acc_now;
    logic hold_go;
    hold_go = 1'b0;
    acc_now = n_accepted;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      idle_cnt  = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_answers.push_back(lookup_and_update(cur));
        acc_now = n_accepted + 1;
        n_accepted <= acc_now;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (idle_cnt < int'(pending_reqs[0].gap)) begin
          idle_cnt++;
          in_tvalid <= 1'b0;
        end else if (pending_reqs[0].drain_first && acc_now != n_results) begin
          in_tvalid <= 1'b0;
        end else begin
          cur       = pending_reqs.pop_front();
          idle_cnt  = 0;
          hold_go   = cur.hold_rx;
          in_tvalid <= 1'b1;
          in_tuser  <= cur.op;
          in_tdata  <= {cur.stamp, cur.mac, cur.ip};
        end
      end
    end
    rx_hold_go <= hold_go;
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_answer();
        n_results <= n_results + 1;
      end
      if (rx_hold_go) begin
        hold_left  <= LONG_HOLD;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ((cycle_cnt % 4000) < 3200 && $urandom_range(0, 99) < 25)
          stall_left <= draw_idle();
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("arp_cache_linear_probe_lru_tb: errors");
      $finish;
    end
  end

  initial begin
    int          i;
    int          p;
    int          r;
    int          profile;
    int          pool_size;
    int          install_share;
    logic [31:0] a;
    logic [31:0] stamp;
    logic [47:0] mac;
    logic [31:0] pool[$];

    for (i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_ip[i]    = '0;
      tbl_mac[i]   = '0;
      tbl_stamp[i] = '0;
    end

    // directed: reserved address, wrap of the probe, in-place update, misses at empty slots
    add_item(OP_RESOLVE, '0, '0, '0);
    add_item(OP_RESOLVE, '1, '1, '1);
    add_item(OP_INSTALL, '0, '1, '1);
    add_item(OP_RESOLVE, '0, '0, 32'h5);
    add_item(OP_INSTALL, '1, '1, '1);
    add_item(OP_INSTALL, 32'h0000_007F, '0, '0);
    add_item(OP_INSTALL, 32'h8000_007F, 48'h0123_4567_89AB, 32'h10);
    add_item(OP_RESOLVE, 32'h8000_007F, '0, 32'h20);
    add_item(OP_RESOLVE, 32'h0000_007F, '1, 32'h8000_0000);
    add_item(OP_INSTALL, '1, 48'hA5A5_5A5A_F00F, 32'h30);
    add_item(OP_RESOLVE, '1, '0, 32'h31);
    add_item(OP_RESOLVE, 32'h0000_017F, '0, 32'h40);
    add_item(OP_RESOLVE, 32'h0000_0001, '0, 32'h41);
    add_item(OP_INSTALL, 32'h0000_0001, 48'h8000_0000_0001, 32'hFFFF_FFFE);
    add_item(OP_RESOLVE, 32'h0000_0001, '0, 32'h50);
    add_item(OP_INSTALL, 32'h0000_0080, 48'h1, 32'h51);
    add_item(OP_RESOLVE, 32'hDEAD_BEEF, '0, 32'h52);
    clock_now = 32'h100;

    // random phases: clustered homes, wide pool with eviction and ties, random stamps
    for (p = 0; p < PHASES; p++) begin
      profile   = p % 3;
      pool_size = (profile == 0) ? 16 : (profile == 1) ? 200 : 64;
      install_share = (profile == 1) ? 60 : 40;
      pool.delete();
      for (i = 0; i < pool_size; i++) begin
        a = $urandom();
        if (profile == 0 || (profile == 2 && $urandom_range(0, 1) == 1))
          a[IDX_W-1:0] = IDX_W'($urandom_range(0, 7) + TABLE_ENTRIES - 4);
        if (a == '0) a = TABLE_ENTRIES;
        pool.push_back(a);
      end
      mark_drain = 1'b1;
      if (p == 2) calm_left = 60;
      if (p == 3) clock_now = 32'hFFFF_FF80;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if ((p == 1 || p == 5) && i == 20) begin
          mark_hold = 1'b1;
          calm_left = 40;
        end
        if (profile == 1 && $urandom_range(0, 1) == 0)
          clock_now = clock_now;
        else
          clock_now = clock_now + $urandom_range(0, 3);
        stamp = (profile == 2 && $urandom_range(0, 4) == 0) ? $urandom() : clock_now;
        mac   = draw_mac();
        a     = pool[$urandom_range(0, pool.size() - 1)];
        r     = $urandom_range(0, 99);
        if (r < install_share)
          add_item(OP_INSTALL, a, mac, stamp);
        else if (r < 88)
          add_item(OP_RESOLVE, a, mac, stamp);
        else if (r < 93)
          add_item(OP_RESOLVE, $urandom(), mac, stamp);
        else if (r < 96)
          add_item(OP_INSTALL, $urandom(), mac, stamp);
        else
          add_item((r % 2 == 0) ? OP_INSTALL : OP_RESOLVE, '0, mac, stamp);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_tvalid || n_accepted != n_results)
      @(negedge clk);
    repeat (TABLE_ENTRIES + 16) @(negedge clk);

    if (expected_answers.size() != 0)
      report_mismatch("transactions never delivered", 96'(expected_answers.size()), '0);

    if (err_count == 0) begin
      $display("arp_cache_linear_probe_lru_tb: clean");
    end else begin
      $display("arp_cache_linear_probe_lru_tb: errors");
    end
    $finish;
  end

endmodule
